// ===== rtl/core/efu_pkg.sv =====
package efu_pkg;

    localparam int QUO_W     = 32;
    localparam int NUM_W     = 64;
    localparam int DEN_W     = 34;
    localparam int ACC_W     = 34;
    localparam int EXP_TERMS = 13;
    localparam int SQ_STEPS  = 4;

    localparam logic [31:0] ONE31 = 32'h8000_0000;

    typedef struct packed {
        logic        neg;
        logic        sat;
        logic        low_br;
        logic [31:0] y28;
    } t_side;

    typedef struct packed {
        logic        neg;
        logic        sat;
        logic        low_br;
        logic [31:0] quo;
    } t_xside;

    // small-argument rational form, Q28
    localparam logic [29:0] P10_Q28 =
        30'((64'd36767877 * 64'd268435456 + 64'd5000000) / 64'd10000000);
    localparam logic [24:0] P11_Q28 =
        25'((64'd97970465 * 64'd268435456 + 64'd500000000) / 64'd1000000000);
    localparam logic [29:0] Q10_Q28 =
        30'((64'd32584593 * 64'd268435456 + 64'd5000000) / 64'd10000000);

    // mid-range Horner coefficients, Q24, index = power of V
    localparam logic [ACC_W-1:0] AP_C [5] = '{
        34'((64'd73738883 * 64'd16777216 + 64'd5000000) / 64'd10000000),
        34'((64'd68650185 * 64'd16777216 + 64'd5000000) / 64'd10000000),
        34'((64'd30317993 * 64'd16777216 + 64'd5000000) / 64'd10000000),
        34'((64'd56316962 * 64'd16777216 + 64'd50000000) / 64'd100000000),
        34'((64'd43187787 * 64'd16777216 + 64'd500000000000) / 64'd1000000000000)
    };
    localparam logic [ACC_W-1:0] AQ_C [5] = '{
        34'((64'd73739609 * 64'd16777216 + 64'd5000000) / 64'd10000000),
        34'((64'd15184908 * 64'd16777216 + 64'd500000) / 64'd1000000),
        34'((64'd1279553 * 64'd16777216 + 64'd50000) / 64'd100000),
        34'((64'd53542168 * 64'd16777216 + 64'd5000000) / 64'd10000000),
        34'd16777216
    };

    // exact floor(x / k) for x < 2^32: (x * RECIP) >> RSH
    localparam logic [32:0] RECIP [EXP_TERMS] = '{
        33'(((64'd1 << 32) + 64'd0) / 64'd1),
        33'(((64'd1 << 33) + 64'd1) / 64'd2),
        33'(((64'd1 << 34) + 64'd2) / 64'd3),
        33'(((64'd1 << 34) + 64'd3) / 64'd4),
        33'(((64'd1 << 35) + 64'd4) / 64'd5),
        33'(((64'd1 << 35) + 64'd5) / 64'd6),
        33'(((64'd1 << 35) + 64'd6) / 64'd7),
        33'(((64'd1 << 35) + 64'd7) / 64'd8),
        33'(((64'd1 << 36) + 64'd8) / 64'd9),
        33'(((64'd1 << 36) + 64'd9) / 64'd10),
        33'(((64'd1 << 36) + 64'd10) / 64'd11),
        33'(((64'd1 << 36) + 64'd11) / 64'd12),
        33'(((64'd1 << 36) + 64'd12) / 64'd13)
    };
    localparam int RSH [EXP_TERMS] = '{32, 33, 34, 34, 35, 35, 35, 35, 36, 36, 36, 36, 36};

    // c + round(v * acc / 2^24)
    function automatic logic [ACC_W-1:0] horner_step(
        input logic [25:0]      v,
        input logic [ACC_W-1:0] acc,
        input logic [ACC_W-1:0] c
    );
        logic [59:0] p;
        logic [59:0] r;
        p = v * acc;
        r = p + 60'd8388608;
        return ACC_W'(c + ACC_W'(r >> 24));
    endfunction

endpackage

// ===== rtl/core/error_function_unit.sv =====
// Fixed-point erf(x): one signed argument with FRAC_BITS fraction bits in, one
// result with FRAC_BITS fraction bits out, limited to [-1, +1]. A new request
// is taken every cycle while o_stall is low; the depth of the pipe is set by
// the 32-stage restoring divider (shared by the rational form below one half
// and the Horner ratio up to four) followed by the 13-term exp(-x^2) series
// with its four squarings. Magnitudes of four and above give exactly +1 or -1.
// A two-entry output buffer lets the pipe keep taking requests while a result
// waits; o_stall rises only once both entries are full.
module error_function_unit import efu_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [FRAC_BITS+7:0]   i_argument,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [FRAC_BITS+1:0]   o_erf_value
);

    localparam int IN_W  = FRAC_BITS + 8;
    localparam int OUT_W = FRAC_BITS + 2;
    localparam logic signed [OUT_W-1:0] ONE_OUT = OUT_W'(2 ** FRAC_BITS);

    logic en;

    // decode
    logic [IN_W-1:0]  c_mag;
    logic [IN_W+27:0] c_ext;
    logic             r1_v, r1_neg, r1_sat, r1_low;
    logic [29:0]      r1_v28;

    // square
    logic [59:0]      c2_rsq;
    logic             r2_v, r2_neg, r2_sat, r2_low;
    logic [29:0]      r2_v28;
    logic [31:0]      r2_y28;

    // Horner / small form
    logic [50:0]      c3_sp;
    logic [51:0]      c3_spr;
    logic             r3_v, r3_neg, r3_sat, r3_low;
    logic [29:0]      r3_v28;
    logic [31:0]      r3_y28;
    logic [ACC_W-1:0] r3_ap, r3_aq;
    logic [29:0]      r3_num, r3_den;

    logic             r4_v, r4_neg, r4_sat, r4_low;
    logic [29:0]      r4_v28;
    logic [31:0]      r4_y28;
    logic [ACC_W-1:0] r4_ap, r4_aq;
    logic [56:0]      r4_prod;
    logic [29:0]      r4_den;

    logic             r5_v, r5_neg, r5_sat, r5_low;
    logic [29:0]      r5_v28;
    logic [31:0]      r5_y28;
    logic [ACC_W-1:0] r5_ap, r5_aq;
    logic [56:0]      r5_prod;
    logic [29:0]      r5_den;

    logic             r6_v, r6_neg, r6_sat, r6_low;
    logic [31:0]      r6_y28;
    logic [ACC_W-1:0] r6_ap, r6_aq;
    logic [56:0]      r6_prod;
    logic [29:0]      r6_den;

    logic [NUM_W-1:0] c6_num;
    logic [DEN_W-1:0] c6_den;
    t_side            c6_side;

    logic             div_v;
    logic [QUO_W-1:0] div_quo;
    t_side            div_side;
    t_xside           c_xside;

    logic             exp_v;
    logic [31:0]      exp_e;
    t_xside           exp_side;

    logic [63:0]      c_cp;
    logic             rc_v;
    logic [32:0]      rc_comp;
    t_xside           rc_side;

    logic [31:0]      c_h31;
    logic [32:0]      c_rnd;
    logic [OUT_W-1:0] c_res;
    logic [OUT_W-1:0] c_lim;
    logic [OUT_W-1:0] c_fin;
    logic             push;

    logic             r_out_v, r_skid_v;
    logic [OUT_W-1:0] r_out_d, r_skid_d;

    assign en      = !r_skid_v;
    assign o_stall = r_skid_v;

    assign c_mag = i_argument[IN_W-1] ? IN_W'(-i_argument) : IN_W'(i_argument);
    assign c_ext = {c_mag, 28'b0};

    assign c2_rsq = r1_v28 * r1_v28 + 60'd134217728;

    assign c3_sp  = P11_Q28 * r2_y28[25:0];
    assign c3_spr = 52'(c3_sp) + 52'd134217728;

    always_comb begin
        c6_num = r6_low ? (NUM_W'({r6_prod, 3'b000}) + NUM_W'(r6_den >> 1))
                        : {r6_ap[32:0], 31'b0};
        c6_den = r6_low ? DEN_W'(r6_den) : r6_aq;
        c6_side.neg    = r6_neg;
        c6_side.sat    = r6_sat;
        c6_side.low_br = r6_low;
        c6_side.y28    = r6_y28;
        c_xside.neg    = div_side.neg;
        c_xside.sat    = div_side.sat;
        c_xside.low_br = div_side.low_br;
        c_xside.quo    = div_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_neg <= i_argument[IN_W-1];
            r1_sat <= |c_mag[IN_W-1:FRAC_BITS+2];
            r1_low <= ~|c_mag[IN_W-1:FRAC_BITS-1];
            r1_v28 <= c_ext[FRAC_BITS +: 30];

            r2_neg <= r1_neg;
            r2_sat <= r1_sat;
            r2_low <= r1_low;
            r2_v28 <= r1_v28;
            r2_y28 <= c2_rsq[59:28];

            r3_neg <= r2_neg;
            r3_sat <= r2_sat;
            r3_low <= r2_low;
            r3_v28 <= r2_v28;
            r3_y28 <= r2_y28;
            r3_ap  <= horner_step(r2_v28[29:4], AP_C[4], AP_C[3]);
            r3_aq  <= horner_step(r2_v28[29:4], AQ_C[4], AQ_C[3]);
            r3_num <= 30'(P10_Q28 - 30'(c3_spr >> 28));
            r3_den <= 30'(Q10_Q28 + 30'(r2_y28[25:0]));

            r4_neg  <= r3_neg;
            r4_sat  <= r3_sat;
            r4_low  <= r3_low;
            r4_v28  <= r3_v28;
            r4_y28  <= r3_y28;
            r4_ap   <= horner_step(r3_v28[29:4], r3_ap, AP_C[2]);
            r4_aq   <= horner_step(r3_v28[29:4], r3_aq, AQ_C[2]);
            r4_prod <= r3_v28[26:0] * r3_num;
            r4_den  <= r3_den;

            r5_neg  <= r4_neg;
            r5_sat  <= r4_sat;
            r5_low  <= r4_low;
            r5_v28  <= r4_v28;
            r5_y28  <= r4_y28;
            r5_ap   <= horner_step(r4_v28[29:4], r4_ap, AP_C[1]);
            r5_aq   <= horner_step(r4_v28[29:4], r4_aq, AQ_C[1]);
            r5_prod <= r4_prod;
            r5_den  <= r4_den;

            r6_neg  <= r5_neg;
            r6_sat  <= r5_sat;
            r6_low  <= r5_low;
            r6_y28  <= r5_y28;
            r6_ap   <= horner_step(r5_v28[29:4], r5_ap, AP_C[0]);
            r6_aq   <= horner_step(r5_v28[29:4], r5_aq, AQ_C[0]);
            r6_prod <= r5_prod;
            r6_den  <= r5_den;
        end
    end

    efu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r6_v),
        .i_num   (c6_num),
        .i_den   (c6_den),
        .i_side  (c6_side),
        .o_valid (div_v),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    efu_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_v),
        .i_y28   (div_side.y28),
        .i_side  (c_xside),
        .o_valid (exp_v),
        .o_exp   (exp_e),
        .o_side  (exp_side)
    );

    assign c_cp = exp_e * exp_side.quo + 64'h4000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rc_v <= 1'b0;
        end else if (en) begin
            rc_v <= exp_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rc_comp <= c_cp[63:31];
            rc_side <= exp_side;
        end
    end

    // pick branch, round to output grid, limit to one, restore sign
    always_comb begin
        if (rc_side.sat) begin
            c_h31 = ONE31;
        end else if (rc_side.low_br) begin
            c_h31 = rc_side.quo;
        end else if (rc_comp >= 33'(ONE31)) begin
            c_h31 = 32'd0;
        end else begin
            c_h31 = 32'(33'(ONE31) - rc_comp);
        end
        c_rnd = 33'(c_h31) + (33'd1 << (30 - FRAC_BITS));
        c_res = c_rnd[32:31-FRAC_BITS];
        c_lim = (c_res > ONE_OUT) ? ONE_OUT : c_res;
        c_fin = rc_side.neg ? OUT_W'(-c_lim) : c_lim;
    end

    assign push = rc_v && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || !i_stall) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= push;
            end
        end else if (push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || !i_stall) begin
            r_out_d <= r_skid_v ? r_skid_d : c_fin;
        end else if (push) begin
            r_skid_d <= c_fin;
        end
    end

    assign o_valid     = r_out_v;
    assign o_erf_value = r_out_d;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held with empty output register");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && i_stall))
        else $error("skid filled without a stalled output");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_erf_value <= ONE_OUT && o_erf_value >= -ONE_OUT))
        else $error("erf result outside [-1, +1]");

endmodule

// ===== rtl/core/efu_div.sv =====
module efu_div import efu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  t_side            i_side,
    output logic             o_valid,
    output logic [QUO_W-1:0] o_quo,
    output t_side            o_side
);

    localparam int SH_W = NUM_W + 2;

    logic             r_v    [QUO_W];
    logic [NUM_W-1:0] r_rem  [QUO_W];
    logic [DEN_W-1:0] r_den  [QUO_W];
    logic [QUO_W-1:0] r_quo  [QUO_W];
    t_side            r_side [QUO_W];

    logic             c_v    [QUO_W];
    logic [NUM_W-1:0] c_rem  [QUO_W];
    logic [DEN_W-1:0] c_den  [QUO_W];
    logic [QUO_W-1:0] c_quo  [QUO_W];
    t_side            c_side [QUO_W];
    logic [SH_W-1:0]  c_dsh  [QUO_W];
    logic             c_ge   [QUO_W];
    logic [NUM_W-1:0] n_rem  [QUO_W];
    logic [QUO_W-1:0] n_quo  [QUO_W];

    // restoring division, one quotient bit per stage, MSB first
    always_comb begin
        for (int g = 0; g < QUO_W; g++) begin
            if (g == 0) begin
                c_v[g]    = i_valid;
                c_rem[g]  = i_num;
                c_den[g]  = i_den;
                c_quo[g]  = '0;
                c_side[g] = i_side;
            end else begin
                c_v[g]    = r_v[g-1];
                c_rem[g]  = r_rem[g-1];
                c_den[g]  = r_den[g-1];
                c_quo[g]  = r_quo[g-1];
                c_side[g] = r_side[g-1];
            end
            c_dsh[g] = SH_W'(c_den[g]) << (QUO_W - 1 - g);
            c_ge[g]  = {2'b00, c_rem[g]} >= c_dsh[g];
            n_rem[g] = c_ge[g] ? (c_rem[g] - c_dsh[g][NUM_W-1:0]) : c_rem[g];
            n_quo[g] = c_quo[g];
            n_quo[g][QUO_W-1-g] = c_ge[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < QUO_W; g++) r_v[g] <= 1'b0;
        end else if (i_en) begin
            for (int g = 0; g < QUO_W; g++) r_v[g] <= c_v[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int g = 0; g < QUO_W; g++) begin
                r_rem[g]  <= n_rem[g];
                r_den[g]  <= c_den[g];
                r_quo[g]  <= n_quo[g];
                r_side[g] <= c_side[g];
            end
        end
    end

    assign o_valid = r_v[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];

endmodule

// ===== rtl/core/efu_exp.sv =====
module efu_exp import efu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [31:0] i_y28,
    input  t_xside      i_side,
    output logic        o_valid,
    output logic [31:0] o_exp,
    output t_xside      o_side
);

    localparam int NT  = EXP_TERMS;
    localparam int NSQ = SQ_STEPS;

    // multiply stage of each term
    logic               r_mv    [NT];
    logic [31:0]        r_mx    [NT];
    logic [30:0]        r_ms    [NT];
    logic signed [33:0] r_msum  [NT];
    t_xside             r_mside [NT];
    // divide-by-k stage of each term
    logic               r_dv    [NT];
    logic [31:0]        r_dterm [NT];
    logic [30:0]        r_ds    [NT];
    logic signed [33:0] r_dsum  [NT];
    t_xside             r_dside [NT];
    // squaring stages
    logic               r_qv    [NSQ];
    logic [31:0]        r_qe    [NSQ];
    t_xside             r_qside [NSQ];

    logic               c_v     [NT];
    logic [31:0]        c_term  [NT];
    logic [30:0]        c_s     [NT];
    logic signed [33:0] c_sum   [NT];
    t_xside             c_side  [NT];
    logic [62:0]        c_mp    [NT];
    logic [64:0]        c_dp    [NT];
    logic [31:0]        n_dterm [NT];
    logic signed [33:0] n_dsum  [NT];
    logic [31:0]        c_qin   [NSQ];
    logic [63:0]        c_qp    [NSQ];
    logic [31:0]        n_qe    [NSQ];

    // Taylor terms s^k/k! with truncation at each step, then four squarings
    always_comb begin
        for (int k = 0; k < NT; k++) begin
            if (k == 0) begin
                c_v[k]    = i_valid;
                c_term[k] = ONE31;
                c_s[k]    = i_y28[31:1];
                c_sum[k]  = 34'sd2147483648;
                c_side[k] = i_side;
            end else begin
                c_v[k]    = r_dv[k-1];
                c_term[k] = r_dterm[k-1];
                c_s[k]    = r_ds[k-1];
                c_sum[k]  = r_dsum[k-1];
                c_side[k] = r_dside[k-1];
            end
            c_mp[k]    = c_term[k] * c_s[k];
            c_dp[k]    = r_mx[k] * RECIP[k];
            n_dterm[k] = 32'(c_dp[k] >> RSH[k]);
            if ((k & 1) == 0) begin
                n_dsum[k] = r_msum[k] - $signed({2'b00, n_dterm[k]});
            end else begin
                n_dsum[k] = r_msum[k] + $signed({2'b00, n_dterm[k]});
            end
        end
        for (int q = 0; q < NSQ; q++) begin
            if (q == 0) begin
                c_qin[q] = r_dsum[NT-1][33] ? 32'd0 : r_dsum[NT-1][31:0];
            end else begin
                c_qin[q] = r_qe[q-1];
            end
            c_qp[q] = c_qin[q] * c_qin[q] + 64'h4000_0000;
            n_qe[q] = c_qp[q][62:31];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NT; k++) begin
                r_mv[k] <= 1'b0;
                r_dv[k] <= 1'b0;
            end
            for (int q = 0; q < NSQ; q++) r_qv[q] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < NT; k++) begin
                r_mv[k] <= c_v[k];
                r_dv[k] <= r_mv[k];
            end
            for (int q = 0; q < NSQ; q++) begin
                r_qv[q] <= (q == 0) ? r_dv[NT-1] : r_qv[q-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NT; k++) begin
                r_mx[k]    <= c_mp[k][62:31];
                r_ms[k]    <= c_s[k];
                r_msum[k]  <= c_sum[k];
                r_mside[k] <= c_side[k];
                r_dterm[k] <= n_dterm[k];
                r_ds[k]    <= r_ms[k];
                r_dsum[k]  <= n_dsum[k];
                r_dside[k] <= r_mside[k];
            end
            for (int q = 0; q < NSQ; q++) begin
                r_qe[q]    <= n_qe[q];
                r_qside[q] <= (q == 0) ? r_dside[NT-1] : r_qside[q-1];
            end
        end
    end

    assign o_valid = r_qv[NSQ-1];
    assign o_exp   = r_qe[NSQ-1];
    assign o_side  = r_qside[NSQ-1];

endmodule

// ===== tb/error_function_unit_test.sv =====
`timescale 1ns / 1ps

module error_function_unit_test;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = FRAC_BITS + 8;
    localparam int OUT_W     = FRAC_BITS + 2;
    localparam longint unsigned ONE_Q31 = 64'h8000_0000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic signed [IN_W-1:0]  i_argument;
    logic                    o_valid;
    logic                    i_stall;
    logic signed [OUT_W-1:0] o_erf_value;

    error_function_unit #(.FRAC_BITS(FRAC_BITS)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_argument  (i_argument),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_erf_value (o_erf_value)
    );

    logic [OUT_W-1:0] erf_expected_q[$];
    int               error_count;
    int               result_count;
    int               sent_count;
    int               send_idle_pct;
    int               stall_pct;
    int               hold_cycles;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Q24 / Q28 constants, nearest step
    function automatic longint unsigned qconst(longint unsigned m, longint unsigned d,
                                               int fb);
        return ((m << fb) + d / 2) / d;
    endfunction

    function automatic longint unsigned exp_neg_q31(longint unsigned t28);
        longint unsigned s, term, e;
        longint sum;
        s    = t28 >> 1;
        term = ONE_Q31;
        sum  = longint'(ONE_Q31);
        for (int k = 1; k <= 13; k++) begin
            term = ((term * s) >> 31) / k;
            if (k % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
        end
        e = (sum < 0) ? 0 : longint'(sum);
        for (int k = 0; k < 4; k++) e = (e * e + (ONE_Q31 >> 1)) >> 31;
        return e;
    endfunction

    function automatic logic [OUT_W-1:0] erf_predict(logic [IN_W-1:0] arg);
        longint unsigned mag, h31, v28, y28, num, den, v24, ap, aq, r, e, comp, res;
        longint unsigned ap_c[5], aq_c[5];
        logic neg;
        ap_c[0] = qconst(73738883, 10000000, 24);
        ap_c[1] = qconst(68650185, 10000000, 24);
        ap_c[2] = qconst(30317993, 10000000, 24);
        ap_c[3] = qconst(56316962, 100000000, 24);
        ap_c[4] = (43187787 * 64'd16777216 + 64'd500000000000) / 64'd1000000000000;
        aq_c[0] = qconst(73739609, 10000000, 24);
        aq_c[1] = qconst(15184908, 1000000, 24);
        aq_c[2] = qconst(1279553, 100000, 24);
        aq_c[3] = qconst(53542168, 10000000, 24);
        aq_c[4] = 64'd16777216;
        neg = arg[IN_W-1];
        mag = neg ? longint'({1'b0, (~arg + 1'b1)}) & ((64'd1 << IN_W) - 1) : arg;
        if (mag >= (64'd4 << FRAC_BITS)) begin
            h31 = ONE_Q31;
        end else begin
            v28 = mag << (28 - FRAC_BITS);
            y28 = (v28 * v28 + (64'd1 << 27)) >> 28;
            if (mag < (64'd1 << (FRAC_BITS - 1))) begin
                num = qconst(36767877, 10000000, 28)
                    - ((qconst(97970465, 1000000000, 28) * y28 + (64'd1 << 27)) >> 28);
                den = qconst(32584593, 10000000, 28) + y28;
                h31 = (v28 * num * 8 + den / 2) / den;
            end else begin
                v24 = v28 >> 4;
                ap  = ap_c[4];
                aq  = aq_c[4];
                for (int c = 3; c >= 0; c--) begin
                    ap = ap_c[c] + ((v24 * ap + (64'd1 << 23)) >> 24);
                    aq = aq_c[c] + ((v24 * aq + (64'd1 << 23)) >> 24);
                end
                r    = (ap << 31) / aq;
                e    = exp_neg_q31(y28);
                comp = (e * r + (ONE_Q31 >> 1)) >> 31;
                h31  = (comp >= ONE_Q31) ? 0 : ONE_Q31 - comp;
            end
        end
        res = (h31 + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS);
        if (res > (64'd1 << FRAC_BITS)) res = 64'd1 << FRAC_BITS;
        if (neg) res = ~res + 1;
        return res[OUT_W-1:0];
    endfunction

    task automatic report_mismatch(string what, logic [OUT_W-1:0] got,
                                   logic [OUT_W-1:0] want);
        error_count++;
        $display("mismatch %s: got %0d want %0d", what, $signed(got), $signed(want));
    endtask

    // valid stays up between back-to-back requests; it drops only while idling
    task automatic send_request(logic [IN_W-1:0] arg);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_argument <= arg;
        erf_expected_q.push_back(erf_predict(arg));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_count++;
        @(negedge i_clk);
    endtask

    // receiver stall, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall     <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= (stall_pct > 0) && ($urandom_range(99, 0) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            result_count++;
            if (erf_expected_q.size() == 0) begin
                report_mismatch("unexpected result", o_erf_value, '0);
            end else begin
                logic [OUT_W-1:0] want;
                want = erf_expected_q.pop_front();
                if (o_erf_value !== want) report_mismatch("erf_value", o_erf_value, want);
            end
        end
    end

    task automatic drain_results();
        i_valid <= 1'b0;
        while (erf_expected_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_directed();
        logic [IN_W-1:0] args[$];
        args = '{0, 1, 24'hFFFFFF, 24'h7FFF, 24'h8000, 24'h8001, 24'hFF8000, 24'hFF7FFF,
                 24'h10000, 24'hFF0000, 24'h3FFFF, 24'h40000, 24'hFC0000, 24'hFC0001,
                 24'h7FFFFF, 24'h800000, 24'h800001, 24'h20000, 24'h2FFFF, 24'hC000};
        foreach (args[i]) send_request(args[i]);
        drain_results();
    endtask

    function automatic logic [IN_W-1:0] random_argument();
        case ($urandom_range(9, 0))
            0, 1:    return IN_W'($urandom_range(32767, 0)) ^ (($urandom & 1) ? '1 : '0);
            2, 3, 4, 5, 6: begin
                logic [IN_W-1:0] a;
                a = IN_W'($urandom_range(262143, 32768));
                return ($urandom & 1) ? -a : a;
            end
            default: return IN_W'($urandom);
        endcase
    endfunction

    task automatic test_random_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        stall_pct     = stall;
        for (int i = 0; i < n; i++) send_request(random_argument());
        drain_results();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        @(negedge i_clk);
        hold_cycles   = 300;
        for (int i = 0; i < 150; i++) send_request(random_argument());
        drain_results();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_argument    = '0;
        error_count   = 0;
        result_count  = 0;
        sent_count    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_cycles   = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random_phase(300, 0, 0);
        test_random_phase(250, 82, 0);
        test_random_phase(250, 0, 82);
        test_random_phase(250, 26, 26);
        test_backpressure();
        stall_pct = 0;
        repeat (100) @(negedge i_clk);
        $display("covered %0d requests, %0d results: small, mid and saturated ranges,",
                 sent_count, result_count);
        $display("both signs, idle and stall phases and a long output hold-off");
        if (error_count == 0) $display("[error_function_unit] OK");
        else $display("[error_function_unit] ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("[error_function_unit] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/efu_pkg.sv
rtl/core/efu_div.sv
rtl/core/efu_exp.sv
rtl/core/error_function_unit.sv
tb/error_function_unit_test.sv
